/* rtl/rme_pkg.sv */
// Shared types, codes and rank weight functions for the ranking metric evaluator.
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;

  localparam int CODE_W  = 32;
  localparam int DIV_NW  = 48;
  localparam int DIV_DW  = 24;
  localparam int WEIGHT_W = 17;
  localparam int IDEAL_W = 23;
  localparam int SUM_W   = 24;
  localparam int USERS_W = 24;

  localparam logic [16:0] Q16_ONE  = 17'd65536;
  localparam logic [18:0] GAIN_MAX = 19'd524287;
  localparam logic [23:0] USERS_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_NEXT   = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  localparam logic KIND_USER   = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CODE_W-1:0] item_code;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [16:0] hit_value;
    logic [16:0] precision_value;
    logic [18:0] gain_value;
    logic        counted;
    logic [23:0] users_counted;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              hit;
  } probe_t;

  // integer part plus 28 fraction bits, fraction by repeated squaring
  function automatic logic [63:0] log2_q28(input int unsigned n);
    logic [63:0] x;
    logic [63:0] frac;
    int unsigned e;
    int unsigned t;
    e = 0;
    t = n;
    frac = '0;
    for (int i = 0; i < 8; i++) begin
      if (t > 1) begin
        t = t >> 1;
        e = e + 1;
      end
    end
    x = (64'(n) << 30) >> e;
    for (int i = 0; i < 28; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << 28) | frac;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rank_weight(input int unsigned r);
    logic [63:0] l;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    l = log2_q28(r + 2);
    num = (64'd1 << 44) + (l >> 1);
    rem = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= l) begin
        rem = rem - l;
        q[i] = 1'b1;
      end
    end
    return q[WEIGHT_W-1:0];
  endfunction

  function automatic logic [IDEAL_W-1:0] ideal_sum(input int unsigned k);
    logic [IDEAL_W-1:0] s;
    s = '0;
    for (int j = 0; j < 64; j++) begin
      if (j < k) s = s + IDEAL_W'(rank_weight(j));
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/ranking_metric_evaluator.sv */
// Top level: hit ratio, MAP and nDCG at TOP_N over a chain of relevant set cells.
// Add: shifts the code into the chain. Recommendation: the probe walks the registered
// cell chain, then takes one pass of the shared divider on a hit.
// Close: up to 2 divider passes; report: up to 3 passes.
// The result register frees the input side while a result waits to be taken.
// Synchronous reset clears all counts and totals; stored codes need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module ranking_metric_evaluator #(
  parameter int TOP_N     = 16,
  parameter int REL_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire rme_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      rme_pkg::out_item_t out_data
);

  localparam int CW  = $clog2(REL_DEPTH + 1);
  localparam int RW  = $clog2(TOP_N + 1);
  localparam int RIW = (TOP_N > 1) ? $clog2(TOP_N) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_PDIV, S_CAP, S_CGAIN, S_RHIT, S_RPREC, S_RGAIN, S_EMIT
  } state_t;

  state_t state;

  logic [rme_pkg::WEIGHT_W-1:0] weight_tab [TOP_N];
  logic [rme_pkg::IDEAL_W-1:0]  ideal_tab  [TOP_N+1];

  for (genvar r = 0; r < TOP_N; r++) begin : g_w
    assign weight_tab[r] = rme_pkg::rank_weight(r);
  end
  for (genvar k = 0; k <= TOP_N; k++) begin : g_i
    assign ideal_tab[k] = rme_pkg::ideal_sum(k);
  end

  logic [CW-1:0]             rel_count;
  logic [RW-1:0]             rank;
  logic [RW-1:0]             hits;
  logic [rme_pkg::SUM_W-1:0] psum;
  logic [rme_pkg::SUM_W-1:0] gsum;
  logic                      ovf;
  logic [23:0]               tot_hits;
  logic [39:0]               tot_prec;
  logic [43:0]               tot_gain;
  logic [23:0]               user_total;
  logic                      res_kind;
  logic [16:0]               res_hit;
  logic [16:0]               res_prec;
  logic [18:0]               res_gain;

  logic                       div_start;
  logic [rme_pkg::DIV_NW-1:0] div_num;
  logic [rme_pkg::DIV_DW-1:0] div_den;
  logic                       div_done;
  logic [rme_pkg::DIV_NW-1:0] div_q;

  rme_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  logic                       accept;
  logic                       do_add;
  logic                       launch;
  rme_pkg::probe_t            probe [REL_DEPTH+1];
  logic [rme_pkg::CODE_W-1:0] ent   [REL_DEPTH];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign do_add   = accept && (in_data.cmd == rme_pkg::CMD_ADD) && (32'(rel_count) < REL_DEPTH);
  assign launch   = accept && (in_data.cmd == rme_pkg::CMD_NEXT) && (32'(rank) < TOP_N);

  assign probe[0].valid = launch;
  assign probe[0].code  = in_data.item_code;
  assign probe[0].hit   = 1'b0;

  for (genvar i = 0; i < REL_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    rme_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (do_add),
      .shift_in ((i == 0) ? in_data.item_code : ent[(i == 0) ? 0 : i - 1]),
      .live     (IDX < rel_count),
      .probe_in (probe[i]),
      .entry    (ent[i]),
      .probe_out(probe[i+1])
    );
  end

  logic [RW-1:0]             lim;
  logic [RW-1:0]             hits_inc;
  logic                      user_cnt;
  logic [18:0]               gain_sat;

  always_comb begin
    if (32'(rel_count) < TOP_N) lim = RW'(rel_count);
    else                        lim = RW'(TOP_N);
    hits_inc = hits + 1'b1;
    user_cnt = (rel_count != '0) && (user_total < rme_pkg::USERS_MAX);
    gain_sat = (div_q > 48'(rme_pkg::GAIN_MAX)) ? rme_pkg::GAIN_MAX : div_q[18:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      div_start  <= 1'b0;
      rel_count  <= '0;
      rank       <= '0;
      hits       <= '0;
      psum       <= '0;
      gsum       <= '0;
      ovf        <= 1'b0;
      tot_hits   <= '0;
      tot_prec   <= '0;
      tot_gain   <= '0;
      user_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.cmd)
              rme_pkg::CMD_ADD: begin
                if (do_add) rel_count <= rel_count + 1'b1;
                else        ovf <= 1'b1;
              end
              rme_pkg::CMD_NEXT: begin
                if (launch) state <= S_PROBE;
              end
              rme_pkg::CMD_CLOSE: begin
                res_kind <= rme_pkg::KIND_USER;
                res_hit  <= (rel_count != '0 && hits != '0) ? rme_pkg::Q16_ONE : '0;
                res_prec <= '0;
                res_gain <= '0;
                if (rel_count == '0) begin
                  state <= S_EMIT;
                end else if (hits != '0) begin
                  div_start <= 1'b1;
                  div_num   <= rme_pkg::DIV_NW'(psum);
                  div_den   <= rme_pkg::DIV_DW'(hits);
                  state     <= S_CAP;
                end else begin
                  div_start <= 1'b1;
                  div_num   <= rme_pkg::DIV_NW'(gsum) << 16;
                  div_den   <= rme_pkg::DIV_DW'(ideal_tab[lim]);
                  state     <= S_CGAIN;
                end
              end
              rme_pkg::CMD_REPORT: begin
                res_kind <= rme_pkg::KIND_TOTALS;
                res_hit  <= '0;
                res_prec <= '0;
                res_gain <= '0;
                if (user_total == '0) begin
                  state <= S_EMIT;
                end else begin
                  div_start <= 1'b1;
                  div_num   <= rme_pkg::DIV_NW'(tot_hits) << 16;
                  div_den   <= user_total;
                  state     <= S_RHIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_PROBE: begin
          if (probe[REL_DEPTH].valid) begin
            if (probe[REL_DEPTH].hit) begin
              hits      <= hits_inc;
              gsum      <= gsum + rme_pkg::SUM_W'(weight_tab[rank[RIW-1:0]]);
              div_start <= 1'b1;
              div_num   <= rme_pkg::DIV_NW'(hits_inc) << 16;
              div_den   <= rme_pkg::DIV_DW'(rank) + 1'b1;
              state     <= S_PDIV;
            end else begin
              rank  <= rank + 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_PDIV: begin
          if (div_done) begin
            psum  <= psum + div_q[rme_pkg::SUM_W-1:0];
            rank  <= rank + 1'b1;
            state <= S_IDLE;
          end
        end
        S_CAP: begin
          if (div_done) begin
            res_prec  <= div_q[16:0];
            div_start <= 1'b1;
            div_num   <= rme_pkg::DIV_NW'(gsum) << 16;
            div_den   <= rme_pkg::DIV_DW'(ideal_tab[lim]);
            state     <= S_CGAIN;
          end
        end
        S_CGAIN: begin
          if (div_done) begin
            res_gain <= gain_sat;
            state    <= S_EMIT;
          end
        end
        S_RHIT: begin
          if (div_done) begin
            res_hit   <= (div_q > 48'(rme_pkg::Q16_ONE)) ? rme_pkg::Q16_ONE : div_q[16:0];
            div_start <= 1'b1;
            div_num   <= rme_pkg::DIV_NW'(tot_prec);
            div_den   <= user_total;
            state     <= S_RPREC;
          end
        end
        S_RPREC: begin
          if (div_done) begin
            res_prec  <= (div_q > 48'(rme_pkg::Q16_ONE)) ? rme_pkg::Q16_ONE : div_q[16:0];
            div_start <= 1'b1;
            div_num   <= rme_pkg::DIV_NW'(tot_gain);
            div_den   <= user_total;
            state     <= S_RGAIN;
          end
        end
        S_RGAIN: begin
          if (div_done) begin
            res_gain <= gain_sat;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_data.kind            <= res_kind;
            out_data.hit_value       <= res_hit;
            out_data.precision_value <= res_prec;
            out_data.gain_value      <= res_gain;
            state                    <= S_IDLE;
            if (res_kind == rme_pkg::KIND_USER) begin
              out_data.counted       <= user_cnt;
              out_data.users_counted <= user_total + 24'(user_cnt);
              out_data.overflow      <= ovf;
              if (user_cnt) begin
                user_total <= user_total + 1'b1;
                tot_hits   <= tot_hits + 24'(res_hit != '0);
                tot_prec   <= tot_prec + 40'(res_prec);
                tot_gain   <= tot_gain + 44'(res_gain);
              end
              rel_count <= '0;
              rank      <= '0;
              hits      <= '0;
              psum      <= '0;
              gsum      <= '0;
              ovf       <= 1'b0;
            end else begin
              out_data.counted       <= 1'b0;
              out_data.users_counted <= user_total;
              out_data.overflow      <= 1'b0;
              user_total <= '0;
              tot_hits   <= '0;
              tot_prec   <= '0;
              tot_gain   <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/rme_cell.sv */
// One cell of the relevant set chain: holds a code and checks the passing probe.
`timescale 1ns / 1ps
`default_nettype none
module rme_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       shift,
  input  wire logic [rme_pkg::CODE_W-1:0] shift_in,
  input  wire logic                       live,
  input  wire rme_pkg::probe_t            probe_in,
  output      logic [rme_pkg::CODE_W-1:0] entry,
  output      rme_pkg::probe_t            probe_out
);

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.code <= probe_in.code;
    probe_out.hit  <= probe_in.hit | (live && (entry == probe_in.code));
  end

endmodule
`default_nettype wire

/* rtl/rme_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rme_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rme_pkg::DIV_NW-1:0] num,
  input  wire logic [rme_pkg::DIV_DW-1:0] den,
  output      logic                       done,
  output      logic [rme_pkg::DIV_NW-1:0] quot
);

  localparam int CNT_W = $clog2(rme_pkg::DIV_NW);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [rme_pkg::DIV_DW-1:0] rem;
  logic [rme_pkg::DIV_DW-1:0] dvs;
  logic [rme_pkg::DIV_DW:0]   trial;
  logic                       ge;

  assign trial = {rem, quot[rme_pkg::DIV_NW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= num;
        dvs  <= den;
        rem  <= '0;
      end else if (busy) begin
        quot <= {quot[rme_pkg::DIV_NW-2:0], ge};
        rem  <= ge ? rme_pkg::DIV_DW'(trial - {1'b0, dvs}) : trial[rme_pkg::DIV_DW-1:0];
        if (cnt == CNT_W'(rme_pkg::DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
